// File: hw/rtl/utli_pkg.sv
package utli_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // Item kinds.
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] CFG_X_OFFSET = 2'd0;
  localparam logic [1:0] CFG_X_STEP   = 2'd1;
  localparam logic [1:0] CFG_RECIP    = 2'd2;
  localparam logic [1:0] CFG_ENTRIES  = 2'd3;

  // Configuration reset values.
  localparam logic [31:0] X_OFFSET_RST = 32'd0;
  localparam logic [30:0] X_STEP_RST   = 31'd65536;
  localparam logic [31:0] RECIP_RST    = 32'd16777216;
  localparam logic [6:0]  ENTRIES_RST  = 7'd2;

  // Interpolation term saturates at 2^34.
  localparam logic [34:0] TERM_MAX = 35'h4_0000_0000;

  typedef struct packed {
    logic               action;
    logic [5:0]         entry_index;
    logic signed [31:0] entry_value;
    logic signed [31:0] x_value;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] y_value;
    logic               extrapolated;
  } out_word_t;

endpackage

// File: hw/rtl/uniform_table_linear_interp.sv
// Linear interpolation in a table of y samples on a uniform x grid, Q16.16.
//
// Input channel: a word is taken at each rising edge with start high; busy
// is always low, so a word may be offered in every cycle. A write word
// stores entry_value into table slot entry_index. A lookup word returns one
// result word; a write word returns none.
// Result channel: out_strobe is high for one cycle with out_word valid. The
// receiver must take it in that cycle; it cannot hold results off.
// Pipeline: a lookup passes eight register stages on its way to the result
// ports. Throughput is one word per cycle; table writes land in the same
// stage where lookups read, so words keep their order.
// Configuration: cfg_ready is always high; write only while no lookup is in
// flight. Registers: 0 x offset, 1 x step, 2 step reciprocal (Q8.24),
// 3 entries in use.
// Reset (synchronous, rst_n low): configuration returns to its defaults and
// the pipeline empties. Table contents are undefined until written.
module uniform_table_linear_interp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  utli_pkg::in_word_t   in_word,
  output logic                 out_strobe,
  output utli_pkg::out_word_t  out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int LATENCY = 8;
  localparam int IW      = utli_pkg::IDX_W;

  // Configuration registers.
  logic signed [31:0] x_offset_r;
  logic [30:0]        x_step_r;
  logic [31:0]        recip_r;
  logic [6:0]         entries_r;

  // Sample table.
  logic [31:0] table_mem [utli_pkg::TABLE_DEPTH];

  // Stage valid bits.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r;
  logic lk1_r, lk2_r;

  // Stage payloads.
  logic [5:0]         widx1_r, widx2_r;
  logic [31:0]        wval1_r, wval2_r;
  logic signed [32:0] xo1_r, xo2_r, xo3_r, xo4_r;
  logic [32:0]        xabs1_r;
  logic               neg2_r;
  logic [24:0]        q2_r;
  logic [IW-1:0]      idx3_r;
  logic               clamp3_r, clamp4_r, clamp5_r, clamp6_r, clamp7_r;
  logic [31:0]        y1_3_r, y2_3_r, y1_4_r, y2_4_r, y1_5_r, y2_5_r;
  logic [31:0]        y1_6_r, y2_6_r, y1_7_r, y2_7_r;
  logic [36:0]        base4_r;
  logic [32:0]        dyabs4_r;
  logic               dyneg4_r, dyneg5_r;
  logic [37:0]        dxabs5_r;
  logic               dxneg5_r;
  logic [63:0]        s5_r;
  logic [69:0]        pl6_r, ph6_r;
  logic               sgn6_r, sgn7_r;
  logic [34:0]        term7_r;
  logic               out_strobe_r;
  utli_pkg::out_word_t out_word_r;

  logic in_take;
  assign in_take   = start & ~busy;
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_offset_r <= utli_pkg::X_OFFSET_RST;
      x_step_r   <= utli_pkg::X_STEP_RST;
      recip_r    <= utli_pkg::RECIP_RST;
      entries_r  <= utli_pkg::ENTRIES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        utli_pkg::CFG_X_OFFSET: x_offset_r <= cfg_data;
        utli_pkg::CFG_X_STEP:   x_step_r   <= cfg_data[30:0];
        utli_pkg::CFG_RECIP:    recip_r    <= cfg_data;
        utli_pkg::CFG_ENTRIES:  entries_r  <= cfg_data[6:0];
      endcase
    end
  end

  // Last usable segment, from the entry count clamped to the table.
  logic [6:0]    n_eff;
  logic [IW-1:0] last;
  always_comb begin
    if (entries_r < 7'd2) begin
      n_eff = 7'd2;
    end else if (32'(entries_r) > utli_pkg::TABLE_DEPTH) begin
      n_eff = 7'(utli_pkg::TABLE_DEPTH);
    end else begin
      n_eff = entries_r;
    end
    last = IW'(n_eff - 7'd2);
  end

  // Stage 1: offset x and take its magnitude.
  logic signed [32:0] xo_nxt;
  logic [32:0]        xabs_nxt;
  always_comb begin
    xo_nxt   = {in_word.x_value[31], in_word.x_value} + {x_offset_r[31], x_offset_r};
    xabs_nxt = xo_nxt[32] ? 33'(-xo_nxt) : 33'(xo_nxt);
  end

  // Stage 2: scale by the reciprocal to get the raw segment number.
  logic [64:0] qprod;
  assign qprod = {32'b0, xabs1_r} * {33'b0, recip_r};

  // Stage 3: clamp the segment index.
  logic [IW-1:0] idx_nxt;
  logic          clamp_nxt;
  always_comb begin
    if (neg2_r && (q2_r != 25'd0)) begin
      idx_nxt   = '0;
      clamp_nxt = 1'b1;
    end else if (!neg2_r && (q2_r > 25'(last))) begin
      idx_nxt   = last;
      clamp_nxt = 1'b1;
    end else begin
      idx_nxt   = neg2_r ? '0 : q2_r[IW-1:0];
      clamp_nxt = 1'b0;
    end
  end

  // Table: writes and both sample reads happen in stage 3, keeping order.
  always_ff @(posedge clk) begin
    if (v2_r && (lk2_r == utli_pkg::ACT_WRITE)) begin
      table_mem[widx2_r[IW-1:0]] <= wval2_r;
    end
    y1_3_r <= table_mem[idx_nxt];
    y2_3_r <= table_mem[idx_nxt + IW'(1)];
  end

  // Stage 4: sample difference and segment start.
  logic signed [32:0] dy_nxt;
  always_comb begin
    dy_nxt = {y2_3_r[31], y2_3_r} - {y1_3_r[31], y1_3_r};
  end

  // Stage 5: distance into the segment and the scaled slope.
  logic signed [38:0] dx_nxt;
  logic [64:0]        sprod;
  always_comb begin
    dx_nxt = {{6{xo4_r[32]}}, xo4_r} - {2'b0, base4_r};
    sprod  = {32'b0, dyabs4_r} * {33'b0, recip_r};
  end

  // Stage 6: distance times slope, in two partial products.
  logic [69:0] pl_nxt, ph_nxt;
  always_comb begin
    pl_nxt = {32'b0, dxabs5_r} * {38'b0, s5_r[31:0]};
    ph_nxt = {32'b0, dxabs5_r} * {38'b0, s5_r[63:32]};
  end

  // Stage 7: combine partial products, drop 40 fraction bits, saturate.
  logic [70:0] tsum;
  logic [34:0] term_nxt;
  always_comb begin
    tsum     = {33'b0, pl6_r[69:32]} + {1'b0, ph6_r};
    term_nxt = (tsum[70:42] != 29'd0) ? utli_pkg::TERM_MAX : {1'b0, tsum[41:8]};
  end

  // Stage 8: add the term to the lower sample and saturate to 32 bits; a zero step gives the upper sample.
  logic signed [35:0] res_wide;
  logic [31:0]        res_nxt;
  always_comb begin
    if (sgn7_r) begin
      res_wide = {{4{y1_7_r[31]}}, y1_7_r} - {1'b0, term7_r};
    end else begin
      res_wide = {{4{y1_7_r[31]}}, y1_7_r} + {1'b0, term7_r};
    end
    if (x_step_r == 31'd0) begin
      res_nxt = y2_7_r;
    end else if (res_wide > 36'sh0_7FFF_FFFF) begin
      res_nxt = 32'h7FFF_FFFF;
    end else if (res_wide < -36'sh0_8000_0000) begin
      res_nxt = 32'h8000_0000;
    end else begin
      res_nxt = res_wide[31:0];
    end
  end

  // Valid bits travel with the words; only lookups go past stage 3.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      v5_r         <= 1'b0;
      v6_r         <= 1'b0;
      v7_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      v1_r         <= in_take;
      v2_r         <= v1_r;
      v3_r         <= v2_r && (lk2_r == utli_pkg::ACT_LOOKUP);
      v4_r         <= v3_r;
      v5_r         <= v4_r;
      v6_r         <= v5_r;
      v7_r         <= v6_r;
      out_strobe_r <= v7_r;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    lk1_r    <= in_word.action;
    widx1_r  <= in_word.entry_index;
    wval1_r  <= in_word.entry_value;
    xo1_r    <= xo_nxt;
    xabs1_r  <= xabs_nxt;

    lk2_r    <= lk1_r;
    widx2_r  <= widx1_r;
    wval2_r  <= wval1_r;
    xo2_r    <= xo1_r;
    neg2_r   <= xo1_r[32];
    q2_r     <= qprod[64:40];

    idx3_r   <= idx_nxt;
    clamp3_r <= clamp_nxt;
    xo3_r    <= xo2_r;

    base4_r  <= 37'(idx3_r) * 37'(x_step_r);
    dyabs4_r <= dy_nxt[32] ? 33'(-dy_nxt) : 33'(dy_nxt);
    dyneg4_r <= dy_nxt[32];
    xo4_r    <= xo3_r;
    y1_4_r   <= y1_3_r;
    y2_4_r   <= y2_3_r;
    clamp4_r <= clamp3_r;

    dxabs5_r <= dx_nxt[38] ? 38'(-dx_nxt) : dx_nxt[37:0];
    dxneg5_r <= dx_nxt[38];
    s5_r     <= sprod[63:0];
    dyneg5_r <= dyneg4_r;
    y1_5_r   <= y1_4_r;
    y2_5_r   <= y2_4_r;
    clamp5_r <= clamp4_r;

    pl6_r    <= pl_nxt;
    ph6_r    <= ph_nxt;
    sgn6_r   <= dxneg5_r ^ dyneg5_r;
    y1_6_r   <= y1_5_r;
    y2_6_r   <= y2_5_r;
    clamp6_r <= clamp5_r;

    term7_r  <= term_nxt;
    sgn7_r   <= sgn6_r;
    y1_7_r   <= y1_6_r;
    y2_7_r   <= y2_6_r;
    clamp7_r <= clamp6_r;

    out_word_r.y_value      <= res_nxt;
    out_word_r.extrapolated <= clamp7_r;
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  // Every result comes exactly the pipeline latency after a lookup word.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |->
      $past(in_take && (in_word.action == utli_pkg::ACT_LOOKUP), LATENCY))
    else $error("result without a matching lookup");

  // The clamped segment index never passes the last usable segment.
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (idx3_r <= last))
    else $error("segment index beyond table end");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int  DRAIN_CYCLES    = 12;
  localparam int  NUM_PHASES      = 8;
  localparam int  ITEMS_PER_PHASE = 40;
  localparam int  MAX_CYCLES      = 200000;
  localparam int  MAX_REPORTS     = 10;
  localparam int  IDLE_PERCENT    = 8;
  localparam int  QUIET_PHASE     = 3;

  // One row of the directed stimulus: either a register write or an input word.
  typedef struct packed {
    logic                is_cfg;
    logic [1:0]          reg_index;
    logic [31:0]         reg_data;
    utli_pkg::in_word_t  word;
    logic                known;
    utli_pkg::out_word_t known_result;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  utli_pkg::in_word_t  in_word;
  logic      out_strobe;
  utli_pkg::out_word_t out_word;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  // Shadow copy of the configuration and of the sample table.
  logic signed [31:0] x_offset_q;
  logic [30:0]        x_step_q;
  logic [31:0]        recip_q;
  logic [6:0]         entries_q;
  logic signed [31:0] samples [utli_pkg::TABLE_DEPTH];
  bit                 sample_written [utli_pkg::TABLE_DEPTH];

  utli_pkg::out_word_t expected_interp [$];
  stim_row_t directed_rows [$];
  utli_pkg::out_word_t want_result;

  bit gaps_on;
  int cycle_count;
  int mismatch_count;
  int n_lookups;
  int n_writes;
  int n_cfg;
  int n_extrap;

  uniform_table_linear_interp dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Expected result of one lookup word, from the shadow table and registers.
  function automatic utli_pkg::out_word_t interp_lookup(logic signed [31:0] xv);
    longint     n, last, xo, dx, dy, y1, y2, res, idx;
    logic [63:0] mxo, q, mdx, mdy, slope, term;
    logic [127:0] prod;
    bit         neg, clamped;
    utli_pkg::out_word_t r;
    n = longint'({57'b0, entries_q});
    if (n < 2) n = 2;
    if (n > utli_pkg::TABLE_DEPTH) n = utli_pkg::TABLE_DEPTH;
    last = n - 2;
    xo = longint'(xv) + longint'(x_offset_q);
    neg = (xo < 0);
    mxo = neg ? -xo : xo;
    q = (mxo * {32'b0, recip_q}) >> 40;
    clamped = 1'b0;
    // A negative position that truncates to zero stays in segment 0 unclamped.
    if (neg && q != 0) begin
      idx = 0;
      clamped = 1'b1;
    end else if (!neg && q > last) begin
      idx = last;
      clamped = 1'b1;
    end else begin
      idx = neg ? 0 : longint'(q);
    end
    y1 = longint'(samples[idx]);
    y2 = longint'(samples[idx + 1]);
    if (x_step_q == 0) begin
      res = y2;
    end else begin
      dx = xo - idx * longint'({33'b0, x_step_q});
      dy = y2 - y1;
      mdx = (dx < 0) ? -dx : dx;
      mdy = (dy < 0) ? -dy : dy;
      slope = mdy * {32'b0, recip_q};
      prod = {64'b0, mdx} * {64'b0, slope};
      if (prod[127:104] != 0) term = {29'b0, utli_pkg::TERM_MAX};
      else term = prod[103:40];
      if (term > {29'b0, utli_pkg::TERM_MAX}) term = {29'b0, utli_pkg::TERM_MAX};
      if ((dx < 0) != (dy < 0)) res = y1 - longint'(term);
      else res = y1 + longint'(term);
    end
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    r.y_value = res[31:0];
    r.extrapolated = clamped;
    return r;
  endfunction

  function automatic stim_row_t word_row(logic act, logic [5:0] slot, logic [31:0] val,
                                         logic [31:0] xv, logic known, logic [31:0] y,
                                         logic ext);
    stim_row_t r;
    r = '0;
    r.word.action = act;
    r.word.entry_index = slot;
    r.word.entry_value = val;
    r.word.x_value = xv;
    r.known = known;
    r.known_result.y_value = y;
    r.known_result.extrapolated = ext;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [1:0] idx, logic [31:0] data);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.reg_index = idx;
    r.reg_data = data;
    return r;
  endfunction

  // Register write; only issued once the pipeline has emptied.
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    start <= 1'b0;
    while (expected_interp.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      utli_pkg::CFG_X_OFFSET: x_offset_q = data;
      utli_pkg::CFG_X_STEP:   x_step_q   = data[30:0];
      utli_pkg::CFG_RECIP:    recip_q    = data;
      utli_pkg::CFG_ENTRIES:  entries_q  = data[6:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Offer one input word, with random idle cycles ahead of it when enabled.
  task automatic send_word(utli_pkg::in_word_t w, bit known,
                           utli_pkg::out_word_t known_res);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (w.action == utli_pkg::ACT_WRITE) begin
      samples[w.entry_index] = w.entry_value;
      sample_written[w.entry_index] = 1'b1;
      n_writes++;
    end else begin
      expected_interp.push_back(known ? known_res : interp_lookup(w.x_value));
      n_lookups++;
    end
    @(negedge clk);
  endtask

  // One random phase: a fresh setting of every register, then a burst of words.
  task automatic run_phase(int p);
    logic [30:0]        stp;
    logic [31:0]        rc;
    logic signed [31:0] off;
    logic [6:0]         cnt;
    longint             rcp, seg, xt;
    int unsigned        pick;
    int                 fill, made;
    utli_pkg::in_word_t w;
    cnt = (p == 0) ? 7'd64 : (p == 1) ? 7'd2 : 7'($urandom_range(2, 64));
    case ($urandom_range(0, 3))
      0: stp = 31'($urandom_range(256, 262144));
      1: stp = 31'd65536;
      2: stp = 31'($urandom_range(1, 32'h7FFFFFFF));
      default: stp = $urandom_range(0, 1) ? 31'd1 : 31'h7FFFFFFF;
    endcase
    // Mostly a matching reciprocal, sometimes an arbitrary one.
    rcp = (longint'(1) <<< 40) / longint'({33'b0, stp});
    if (rcp > 64'sh0FFFFFFFF) rcp = 64'sh0FFFFFFFF;
    if (rcp == 0) rcp = 1;
    rc = rcp[31:0];
    if ($urandom_range(0, 4) == 0) rc = $urandom_range(1, 32'hFFFFFFFF);
    pick = $urandom_range(0, 9);
    if (pick < 4) off = $urandom;
    else if (pick < 8) off = $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
    else if (pick == 8) off = 32'h7FFFFFFF;
    else off = 32'h80000000;
    write_reg(utli_pkg::CFG_X_OFFSET, off);
    write_reg(utli_pkg::CFG_X_STEP, {1'b0, stp});
    write_reg(utli_pkg::CFG_RECIP, rc);
    write_reg(utli_pkg::CFG_ENTRIES, {25'b0, cnt});
    gaps_on = (p != QUIET_PHASE);
    made = 0;
    while (made < ITEMS_PER_PHASE) begin
      w.action      = utli_pkg::ACT_LOOKUP;
      w.entry_index = 6'($urandom_range(0, 63));
      w.entry_value = $urandom;
      w.x_value     = $urandom;
      // Every sample a lookup can reach is written before the first lookup.
      fill = -1;
      for (int k = int'(cnt) - 1; k >= 0; k--) if (!sample_written[k]) fill = k;
      if (fill >= 0) begin
        w.action = utli_pkg::ACT_WRITE;
        w.entry_index = 6'(fill);
      end else begin
        made++;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          w.action = utli_pkg::ACT_WRITE;
          if ($urandom_range(0, 1)) w.entry_value = $urandom_range(0, 32'h001FFFFF) - 32'h00100000;
        end else if (pick < 80) begin
          // Aim at a segment, from one before the first to two past the last.
          seg = longint'($urandom_range(0, int'(cnt) + 1)) - 1;
          xt = seg * longint'({33'b0, stp}) + longint'($urandom_range(0, stp - 1))
               - longint'(off);
          w.x_value = xt[31:0];
        end else if (pick >= 95) begin
          case ($urandom_range(0, 3))
            0: w.x_value = 32'h7FFFFFFF;
            1: w.x_value = 32'h80000000;
            2: w.x_value = 32'h00000000;
            default: w.x_value = 32'hFFFFFFFF;
          endcase
        end
      end
      send_word(w, 1'b0, '0);
    end
  endtask

  // Result checker and run watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > MAX_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_interp.size());
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_n && out_strobe) begin
      if (out_word.extrapolated) n_extrap++;
      if (expected_interp.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("Unexpected result word y=%h ext=%b at cycle %0d",
                   out_word.y_value, out_word.extrapolated, cycle_count);
      end else begin
        want_result = expected_interp.pop_front();
        if (out_word.y_value !== want_result.y_value ||
            out_word.extrapolated !== want_result.extrapolated) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("Mismatch at cycle %0d: y exp %h got %h, ext exp %b got %b",
                     cycle_count, want_result.y_value, out_word.y_value,
                     want_result.extrapolated, out_word.extrapolated);
        end
      end
    end
  end

  initial begin
    int drain_wait;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_word   = '0;
    cfg_valid = 1'b0;
    cfg_index = utli_pkg::CFG_X_OFFSET;
    cfg_data  = '0;
    gaps_on   = 1'b1;
    cycle_count = 0;
    mismatch_count = 0;
    n_lookups = 0;
    n_writes = 0;
    n_cfg = 0;
    n_extrap = 0;
    x_offset_q = utli_pkg::X_OFFSET_RST;
    x_step_q   = utli_pkg::X_STEP_RST;
    recip_q    = utli_pkg::RECIP_RST;
    entries_q  = utli_pkg::ENTRIES_RST;
    foreach (samples[k]) begin
      samples[k] = '0;
      sample_written[k] = 1'b0;
    end

    // Directed rows: reset defaults (step 1.0, two entries) first.
    directed_rows.push_back(word_row(utli_pkg::ACT_WRITE, 6'd0, 32'h00000000, 32'h0,
                                     1'b0, 32'h0, 1'b0));
    directed_rows.push_back(word_row(utli_pkg::ACT_WRITE, 6'd1, 32'h00010000, 32'h0,
                                     1'b0, 32'h0, 1'b0));
    directed_rows.push_back(word_row(utli_pkg::ACT_LOOKUP, 6'd0, 32'h0, 32'h00000000,
                                     1'b1, 32'h00000000, 1'b0));
    directed_rows.push_back(word_row(utli_pkg::ACT_LOOKUP, 6'd0, 32'h0, 32'h00008000,
                                     1'b1, 32'h00008000, 1'b0));
    directed_rows.push_back(word_row(utli_pkg::ACT_LOOKUP, 6'd0, 32'h0, 32'h7FFFFFFF,
                                     1'b1, 32'h7FFFFFFF, 1'b1));
    directed_rows.push_back(word_row(utli_pkg::ACT_LOOKUP, 6'd0, 32'h0, 32'h80000000,
                                     1'b1, 32'h80000000, 1'b1));
    // Slightly negative input truncates into segment 0 without clamping.
    directed_rows.push_back(word_row(utli_pkg::ACT_LOOKUP, 6'd0, 32'h0, 32'hFFFFFFFF,
                                     1'b1, 32'hFFFFFFFF, 1'b0));
    directed_rows.push_back(word_row(utli_pkg::ACT_WRITE, 6'd63, 32'h7FFFFFFF, 32'h0,
                                     1'b0, 32'h0, 1'b0));
    directed_rows.push_back(word_row(utli_pkg::ACT_WRITE, 6'd62, 32'h80000000, 32'h0,
                                     1'b0, 32'h0, 1'b0));
    // Full table: only the two end segments are read here.
    directed_rows.push_back(cfg_row(utli_pkg::CFG_ENTRIES, 32'd64));
    directed_rows.push_back(word_row(utli_pkg::ACT_LOOKUP, 6'd0, 32'h0, 32'h00000000,
                                     1'b0, 32'h0, 1'b0));
    directed_rows.push_back(word_row(utli_pkg::ACT_LOOKUP, 6'd0, 32'h0, 32'h7FFFFFFF,
                                     1'b0, 32'h0, 1'b0));
    directed_rows.push_back(word_row(utli_pkg::ACT_LOOKUP, 6'd0, 32'h0, 32'h80000000,
                                     1'b0, 32'h0, 1'b0));
    directed_rows.push_back(word_row(utli_pkg::ACT_LOOKUP, 6'd0, 32'h0, 32'h003E8000,
                                     1'b0, 32'h0, 1'b0));
    // Offset extremes push the offset input beyond 32 bits.
    directed_rows.push_back(cfg_row(utli_pkg::CFG_X_OFFSET, 32'h7FFFFFFF));
    directed_rows.push_back(word_row(utli_pkg::ACT_LOOKUP, 6'd0, 32'h0, 32'h7FFFFFFF,
                                     1'b0, 32'h0, 1'b0));
    directed_rows.push_back(cfg_row(utli_pkg::CFG_X_OFFSET, 32'h80000000));
    directed_rows.push_back(word_row(utli_pkg::ACT_LOOKUP, 6'd0, 32'h0, 32'h80000000,
                                     1'b0, 32'h0, 1'b0));
    directed_rows.push_back(cfg_row(utli_pkg::CFG_X_OFFSET, 32'h00000000));
    // Step and reciprocal extremes.
    directed_rows.push_back(cfg_row(utli_pkg::CFG_RECIP, 32'hFFFFFFFF));
    directed_rows.push_back(cfg_row(utli_pkg::CFG_X_STEP, 32'd1));
    directed_rows.push_back(word_row(utli_pkg::ACT_LOOKUP, 6'd0, 32'h0, 32'h00010000,
                                     1'b0, 32'h0, 1'b0));
    directed_rows.push_back(cfg_row(utli_pkg::CFG_RECIP, 32'd1));
    directed_rows.push_back(cfg_row(utli_pkg::CFG_X_STEP, 32'h7FFFFFFF));
    directed_rows.push_back(word_row(utli_pkg::ACT_LOOKUP, 6'd0, 32'h0, 32'h00000005,
                                     1'b0, 32'h0, 1'b0));
    directed_rows.push_back(word_row(utli_pkg::ACT_LOOKUP, 6'd0, 32'h0, 32'h7FFFFFFF,
                                     1'b0, 32'h0, 1'b0));
    // A zero reciprocal pins the lookup to the first sample with no slope.
    directed_rows.push_back(cfg_row(utli_pkg::CFG_RECIP, 32'd0));
    directed_rows.push_back(word_row(utli_pkg::ACT_LOOKUP, 6'd0, 32'h0, 32'h00123456,
                                     1'b1, 32'h00000000, 1'b0));
    // A zero step returns the upper sample of the segment.
    directed_rows.push_back(cfg_row(utli_pkg::CFG_X_STEP, 32'd0));
    directed_rows.push_back(word_row(utli_pkg::ACT_LOOKUP, 6'd0, 32'h0, 32'h00123456,
                                     1'b1, 32'h00010000, 1'b0));

    // Synchronous reset, released at a falling edge.
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg)
        write_reg(directed_rows[i].reg_index, directed_rows[i].reg_data);
      else
        send_word(directed_rows[i].word, directed_rows[i].known, directed_rows[i].known_result);
    end

    for (int p = 0; p < NUM_PHASES; p++) run_phase(p);

    // Let the pipeline empty, then keep waiting so that stray results show.
    start <= 1'b0;
    drain_wait = 0;
    while (expected_interp.size() != 0 && drain_wait < 1000) begin
      @(negedge clk);
      drain_wait++;
    end
    repeat (2 * DRAIN_CYCLES) @(negedge clk);
    if (expected_interp.size() != 0) begin
      $display("%0d expected results never arrived", expected_interp.size());
      mismatch_count += expected_interp.size();
    end

    $display("Covered %0d lookups (%0d clamped at a table end) and %0d table writes,",
             n_lookups, n_extrap, n_writes);
    $display("across %0d register writes and %0d random settings; %0d mismatches.",
             n_cfg, NUM_PHASES, mismatch_count);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/utli_pkg.sv
hw/rtl/uniform_table_linear_interp.sv
tb/sv/testbench.sv
